// File: rtl/ssched_pkg.sv
// ----------------------------------------------------------------------------
// ssched_pkg
// Shared widths and register indexes for the scatter step schedule block.
// ----------------------------------------------------------------------------
package ssched_pkg;

    localparam int N_W           = 7;   // group size and reduced positions
    localparam int POS_W         = 6;   // position fields
    localparam int STEP_W        = 3;   // step number and step total
    localparam int DV_W          = 9;   // dividend of the remainder unit, holds 2^8
    localparam int KW            = $clog2(DV_W);
    localparam int CNT_W         = 6;   // slice count field
    localparam int MAX_RESULTS   = 32;
    localparam int DEF_MAX_RANKS = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_RANK_COUNT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_POSITION  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_POSITION = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TOTAL    = CFG_IDX_W'(3);

endpackage

// File: rtl/scatter_step_schedule.sv
// ----------------------------------------------------------------------------
// scatter_step_schedule
// Per-step role, partner and slice list for a binomial-tree scatter.
//
// Configure rank_count, own_position, root_position and step_total through
// i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle. Each beat on the
// slave stream carries a step number; the block answers with one beat per
// slice moved at that step (tuser: direction, tdata: partner, slice index,
// slice count), tlast on the final beat. An idle step gives a single beat
// with direction idle and zero fields.
// Four reductions modulo the group size run one after another on one shared
// remainder unit before the first result beat; a receive step runs one more
// reduction for the partner. Beats then follow one per cycle while
// m_axis_tready is high, up to 32. s_axis_tready is high only when no item
// is in flight, so a new step is not taken until its last result beat is out.
// Reset clears the handshake state and loads the register reset values.
// A stall on m_axis_tready holds the current beat and pauses the slice walk.
// ----------------------------------------------------------------------------
module scatter_step_schedule
    import ssched_pkg::*;
#(
    parameter int MAX_RANKS = DEF_MAX_RANKS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [2:0] step_number
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // [5:0] partner_position,
                                                  // [11:6] slice_index,
                                                  // [17:12] slice_count
    output logic [1:0]            m_axis_tuser,   // [1:0] direction
    output logic                  m_axis_tlast
);

    localparam int MaxSat = (MAX_RANKS > (1 << N_W) - 1) ? (1 << N_W) - 1 : MAX_RANKS;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DECIDE, ST_EMIT} t_state;
    typedef enum logic [2:0] {OP_OWN, OP_ROOT, OP_PAIR, OP_STEP, OP_RPART} t_op;
    typedef enum logic [1:0] {DIR_IDLE = 2'd0, DIR_SEND = 2'd1, DIR_RECV = 2'd2} t_dir;

    // configuration
    logic [N_W-1:0]    r_rank_count;
    logic [POS_W-1:0]  r_own_position;
    logic [POS_W-1:0]  r_root_position;
    logic [STEP_W-1:0] r_step_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank_count    <= N_W'(1);
            r_own_position  <= '0;
            r_root_position <= '0;
            r_step_total    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RANK_COUNT:    r_rank_count    <= i_cfg_data[N_W-1:0];
                CFG_OWN_POSITION:  r_own_position  <= i_cfg_data[POS_W-1:0];
                CFG_ROOT_POSITION: r_root_position <= i_cfg_data[POS_W-1:0];
                CFG_STEP_TOTAL:    r_step_total    <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    t_state            r_state;
    t_op               r_op;
    logic [STEP_W-1:0] r_s;
    logic [N_W-1:0]    r_own;
    logic [N_W-1:0]    r_root;
    logic [N_W-1:0]    r_pairm;
    logic [N_W-1:0]    r_stepm;
    t_dir              r_dir;
    logic [N_W-1:0]    r_partner;
    logic [N_W-1:0]    r_idx;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_left;
    logic              r_tvalid;

    logic [N_W-1:0]    n_eff;
    logic [DV_W-1:0]   pair;
    logic [DV_W-1:0]   slice_step;
    logic              accept;
    logic              out_beat;
    logic              mod_start;
    logic [DV_W-1:0]   mod_dvd;
    logic              mod_done;
    logic [N_W-1:0]    mod_rem;

    always_comb begin
        if (r_rank_count == '0) begin
            n_eff = N_W'(1);
        end else if (r_rank_count > N_W'(MaxSat)) begin
            n_eff = N_W'(MaxSat);
        end else begin
            n_eff = r_rank_count;
        end
    end

    assign pair       = DV_W'(1) << r_s;
    assign slice_step = DV_W'(1) << ({1'b0, r_s} + 4'd1);
    assign accept     = s_axis_tvalid && s_axis_tready;
    assign out_beat   = r_tvalid && m_axis_tready;

    // role decision
    logic              pow2;
    logic              shortened;
    logic [DV_W-1:0]   members;
    logic [N_W:0]      delta_raw;
    logic [N_W-1:0]    delta;
    logic              is_send;
    logic              is_recv;
    logic [N_W:0]      psend_raw;
    logic [N_W-1:0]    psend;
    logic [DV_W-1:0]   slices;
    logic [CNT_W-1:0]  count;
    logic [N_W:0]      step_raw;
    logic [N_W-1:0]    n_idx;

    always_comb begin
        pow2      = (n_eff & (n_eff - N_W'(1))) == '0;
        shortened = !pow2 && (r_step_total != '0) && (r_s == r_step_total - STEP_W'(1));
        if (!shortened) begin
            members = pair;
        end else if (DV_W'(n_eff) > pair) begin
            members = DV_W'(n_eff) - pair;
        end else begin
            members = '0;
        end

        delta_raw = (N_W+1)'(r_root) + (N_W+1)'(n_eff) - (N_W+1)'(r_own);
        delta     = (delta_raw >= (N_W+1)'(n_eff)) ?
                    N_W'(delta_raw - (N_W+1)'(n_eff)) : delta_raw[N_W-1:0];
        is_send   = DV_W'(delta) < members;
        is_recv   = (DV_W'(delta) >= pair) && (DV_W'(delta) < members + pair);

        psend_raw = (N_W+1)'(r_own) + (N_W+1)'(n_eff) - (N_W+1)'(r_pairm);
        psend     = (psend_raw >= (N_W+1)'(n_eff)) ?
                    N_W'(psend_raw - (N_W+1)'(n_eff)) : psend_raw[N_W-1:0];

        slices = (DV_W'(n_eff) - DV_W'(1) + pair) >> ({1'b0, r_s} + 4'd1);
        count  = (slices > DV_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : slices[CNT_W-1:0];

        // next slice: step back by 2^(s+1) modulo the group size
        step_raw = (N_W+1)'(r_idx) + (N_W+1)'(n_eff) - (N_W+1)'(r_stepm);
        n_idx    = (step_raw >= (N_W+1)'(n_eff)) ?
                   N_W'(step_raw - (N_W+1)'(n_eff)) : step_raw[N_W-1:0];
    end

    // operand for the remainder unit
    always_comb begin
        mod_start = 1'b0;
        mod_dvd   = '0;
        case (r_state)
            ST_IDLE: begin
                mod_start = accept;
                mod_dvd   = DV_W'(r_own_position);
            end
            ST_RUN: begin
                if (mod_done) begin
                    case (r_op)
                        OP_OWN: begin
                            mod_start = 1'b1;
                            mod_dvd   = DV_W'(r_root_position);
                        end
                        OP_ROOT: begin
                            mod_start = 1'b1;
                            mod_dvd   = pair;
                        end
                        OP_PAIR: begin
                            mod_start = 1'b1;
                            mod_dvd   = slice_step;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DECIDE: begin
                mod_start = is_recv && !is_send;
                mod_dvd   = DV_W'(r_own) + pair;
            end
            default: ;
        endcase
    end

    ssched_modu u_modu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dvd),
        .i_divisor  (n_eff),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_tvalid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_s     <= s_axis_tdata[STEP_W-1:0];
                        r_op    <= OP_OWN;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (mod_done) begin
                        case (r_op)
                            OP_OWN: begin
                                r_own <= mod_rem;
                                r_op  <= OP_ROOT;
                            end
                            OP_ROOT: begin
                                r_root <= mod_rem;
                                r_op   <= OP_PAIR;
                            end
                            OP_PAIR: begin
                                r_pairm <= mod_rem;
                                r_op    <= OP_STEP;
                            end
                            OP_STEP: begin
                                r_stepm <= mod_rem;
                                r_state <= ST_DECIDE;
                            end
                            OP_RPART: begin
                                r_partner <= mod_rem;
                                r_tvalid  <= 1'b1;
                                r_state   <= ST_EMIT;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_DECIDE: begin
                    if (is_send) begin
                        r_dir     <= DIR_SEND;
                        r_partner <= psend;
                        r_count   <= count;
                        r_left    <= (count == '0) ? CNT_W'(1) : count;
                        r_idx     <= (count == '0) ? '0 : psend;
                        r_tvalid  <= 1'b1;
                        r_state   <= ST_EMIT;
                    end else if (is_recv) begin
                        r_dir     <= DIR_RECV;
                        r_partner <= '0;
                        r_count   <= count;
                        r_left    <= (count == '0) ? CNT_W'(1) : count;
                        r_idx     <= (count == '0) ? '0 : r_own;
                        r_op      <= OP_RPART;
                        r_state   <= ST_RUN;
                    end else begin
                        r_dir     <= DIR_IDLE;
                        r_partner <= '0;
                        r_count   <= '0;
                        r_left    <= CNT_W'(1);
                        r_idx     <= '0;
                        r_tvalid  <= 1'b1;
                        r_state   <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_beat) begin
                        if (r_left == CNT_W'(1)) begin
                            r_tvalid <= 1'b0;
                            r_state  <= ST_IDLE;
                        end else begin
                            r_left <= r_left - CNT_W'(1);
                            r_idx  <= n_idx;
                        end
                    end
                end
                default: begin
                    r_tvalid <= 1'b0;
                    r_state  <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tuser  = r_dir;
    assign m_axis_tlast  = (r_left == CNT_W'(1));
    assign m_axis_tdata  = {6'b0, r_count, r_idx[POS_W-1:0], r_partner[POS_W-1:0]};

    // no new step is taken while result beats are pending
    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while result beat pending");

    // a step with no slices gives exactly one beat
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_count == '0) |-> m_axis_tlast)
        else $error("zero-slice step not closed by a single beat");

    // idle beats carry no partner and no slice
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_dir == DIR_IDLE) |->
            (r_partner == '0 && r_idx == '0 && r_count == '0))
        else $error("idle beat with nonzero fields");

    // the slice walk stays inside the group
    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_idx < n_eff && r_partner < n_eff))
        else $error("slice index or partner outside the group");

    // a beat count never exceeds the capped slice count
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_count != '0) |-> (r_left <= r_count && r_left != '0))
        else $error("remaining beat count out of range");

endmodule

// File: rtl/ssched_modu.sv
// ----------------------------------------------------------------------------
// ssched_modu
// Restoring remainder unit: dividend mod divisor, one trial subtract per cycle.
// ----------------------------------------------------------------------------
module ssched_modu
    import ssched_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DV_W-1:0]  i_dividend,
    input  logic [N_W-1:0]   i_divisor,
    output logic             o_done,
    output logic [N_W-1:0]   o_rem
);

    logic                  r_busy;
    logic [KW-1:0]         r_k;
    logic [DV_W-1:0]       r_rem;

    logic [DV_W+N_W-1:0]   shifted;
    logic                  fits;
    logic [DV_W-1:0]       n_rem;

    always_comb begin
        shifted = (DV_W+N_W)'(i_divisor) << r_k;
        fits    = (DV_W+N_W)'(r_rem) >= shifted;
        n_rem   = fits ? (r_rem - shifted[DV_W-1:0]) : r_rem;
    end

    // remainder is final on the cycle the last bit position is tried
    assign o_done = r_busy && (r_k == '0);
    assign o_rem  = n_rem[N_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_k    <= KW'(DV_W-1);
            r_rem  <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_k   <= r_k - KW'(1);
            if (r_k == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule
